[rtl/lti_pkg.sv]
// Shared types, constants and the microprogram of the segment/triangle test.
// Used by line_triangle_intersect and lti_rf; depends on nothing else.
package lti_pkg;

	// Exact intermediates stay below 2^243 in magnitude, so 256 bits hold them.
	localparam int LTI_W     = 256;
	localparam int RF_DEPTH  = 32;
	localparam int RF_AW     = $clog2(RF_DEPTH);
	localparam int PC_W      = 7;
	localparam int RES_FRAC  = 16;
	localparam int RES_W     = RES_FRAC + 1;
	localparam int CRD_W     = 32;
	localparam int DIV_STEPS = RES_FRAC + 1;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [RES_W-1:0] RES_ONE = RES_W'(1) << RES_FRAC;

	typedef enum logic [2:0] {
		OP_SUBC,	// dst = coordinate a - coordinate b
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_TNZ,		// note a non-zero operand
		OP_CHK,		// drop the item as a miss if nothing non-zero was noted
		OP_DIV,		// bounded ratio into a result slot
		OP_END
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [RF_AW-1:0] dst;
		logic [RF_AW-1:0] a;
		logic [RF_AW-1:0] b;
	} uop_t;

	typedef struct packed {
		logic             we;
		logic [RF_AW-1:0] addr;
		logic [LTI_W-1:0] data;
	} rf_wr_t;

	// Register file entries.
	localparam logic [RF_AW-1:0] R_U0 = 5'd0,  R_U1 = 5'd1,  R_U2 = 5'd2;
	localparam logic [RF_AW-1:0] R_V0 = 5'd3,  R_V1 = 5'd4,  R_V2 = 5'd5;
	localparam logic [RF_AW-1:0] R_R0 = 5'd6,  R_R1 = 5'd7,  R_R2 = 5'd8;
	localparam logic [RF_AW-1:0] R_W0 = 5'd9,  R_W1 = 5'd10, R_W2 = 5'd11;
	localparam logic [RF_AW-1:0] R_N0 = 5'd12, R_N1 = 5'd13, R_N2 = 5'd14;
	localparam logic [RF_AW-1:0] R_T1 = 5'd15, R_T2 = 5'd16, R_T3 = 5'd17;
	localparam logic [RF_AW-1:0] R_AN = 5'd18, R_BN = 5'd19;
	localparam logic [RF_AW-1:0] R_UU = 5'd20, R_UV = 5'd21, R_VV = 5'd22;
	localparam logic [RF_AW-1:0] R_WU = 5'd23, R_WV = 5'd24, R_DD = 5'd25;
	localparam logic [RF_AW-1:0] R_DEN = 5'd26, R_NX = 5'd27, R_NY = 5'd28;
	localparam logic [RF_AW-1:0] R_NZ = 5'd29, R_ZERO = 5'd30;

	// Coordinate codes for OP_SUBC: vertices a, b, c, segment start, end.
	localparam logic [RF_AW-1:0] K_A0 = 5'd0,  K_A1 = 5'd1,  K_A2 = 5'd2;
	localparam logic [RF_AW-1:0] K_B0 = 5'd3,  K_B1 = 5'd4,  K_B2 = 5'd5;
	localparam logic [RF_AW-1:0] K_C0 = 5'd6,  K_C1 = 5'd7,  K_C2 = 5'd8;
	localparam logic [RF_AW-1:0] K_S0 = 5'd9,  K_S1 = 5'd10, K_S2 = 5'd11;
	localparam logic [RF_AW-1:0] K_E0 = 5'd12, K_E1 = 5'd13, K_E2 = 5'd14;

	// Result slots for OP_DIV.
	localparam logic [RF_AW-1:0] S_T = 5'd0, S_WA = 5'd1, S_WB = 5'd2, S_WZ = 5'd3;
	localparam logic [RF_AW-1:0] NA = 5'd0;

	localparam logic [PC_W-1:0] PROG_LAST = 7'd96;

	function automatic uop_t mk(op_t op, logic [RF_AW-1:0] d, logic [RF_AW-1:0] a,
			logic [RF_AW-1:0] b);
		uop_t u;
		u.op  = op;
		u.dst = d;
		u.a   = a;
		u.b   = b;
		return u;
	endfunction

	// Second multiply operand is always the narrower one: the multiplier
	// walks its bits.
	function automatic uop_t prog(logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			7'd0:  u = mk(OP_SUBC, R_U0, K_A0, K_C0);
			7'd1:  u = mk(OP_SUBC, R_U1, K_A1, K_C1);
			7'd2:  u = mk(OP_SUBC, R_U2, K_A2, K_C2);
			7'd3:  u = mk(OP_SUBC, R_V0, K_B0, K_C0);
			7'd4:  u = mk(OP_SUBC, R_V1, K_B1, K_C1);
			7'd5:  u = mk(OP_SUBC, R_V2, K_B2, K_C2);
			7'd6:  u = mk(OP_SUBC, R_R0, K_E0, K_S0);
			7'd7:  u = mk(OP_SUBC, R_R1, K_E1, K_S1);
			7'd8:  u = mk(OP_SUBC, R_R2, K_E2, K_S2);
			7'd9:  u = mk(OP_SUBC, R_W0, K_S0, K_C0);
			7'd10: u = mk(OP_SUBC, R_W1, K_S1, K_C1);
			7'd11: u = mk(OP_SUBC, R_W2, K_S2, K_C2);
			7'd12: u = mk(OP_SUBC, R_ZERO, K_C0, K_C0);
			// normal n = v x u
			7'd13: u = mk(OP_MUL, R_T1, R_V1, R_U2);
			7'd14: u = mk(OP_MUL, R_T2, R_V2, R_U1);
			7'd15: u = mk(OP_SUB, R_N0, R_T1, R_T2);
			7'd16: u = mk(OP_MUL, R_T1, R_V2, R_U0);
			7'd17: u = mk(OP_MUL, R_T2, R_V0, R_U2);
			7'd18: u = mk(OP_SUB, R_N1, R_T1, R_T2);
			7'd19: u = mk(OP_MUL, R_T1, R_V0, R_U1);
			7'd20: u = mk(OP_MUL, R_T2, R_V1, R_U0);
			7'd21: u = mk(OP_SUB, R_N2, R_T1, R_T2);
			7'd22: u = mk(OP_TNZ, NA, R_N0, NA);
			7'd23: u = mk(OP_TNZ, NA, R_N1, NA);
			7'd24: u = mk(OP_TNZ, NA, R_N2, NA);
			7'd25: u = mk(OP_CHK, NA, NA, NA);
			// an = -(n . w0)
			7'd26: u = mk(OP_MUL, R_T1, R_N0, R_W0);
			7'd27: u = mk(OP_MUL, R_T2, R_N1, R_W1);
			7'd28: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd29: u = mk(OP_MUL, R_T2, R_N2, R_W2);
			7'd30: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd31: u = mk(OP_SUB, R_AN, R_ZERO, R_T1);
			// bn = n . ray
			7'd32: u = mk(OP_MUL, R_T1, R_N0, R_R0);
			7'd33: u = mk(OP_MUL, R_T2, R_N1, R_R1);
			7'd34: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd35: u = mk(OP_MUL, R_T2, R_N2, R_R2);
			7'd36: u = mk(OP_ADD, R_BN, R_T1, R_T2);
			7'd37: u = mk(OP_TNZ, NA, R_BN, NA);
			7'd38: u = mk(OP_CHK, NA, NA, NA);
			7'd39: u = mk(OP_DIV, S_T, R_AN, R_BN);
			// uu, uv, vv
			7'd40: u = mk(OP_MUL, R_T1, R_U0, R_U0);
			7'd41: u = mk(OP_MUL, R_T2, R_U1, R_U1);
			7'd42: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd43: u = mk(OP_MUL, R_T2, R_U2, R_U2);
			7'd44: u = mk(OP_ADD, R_UU, R_T1, R_T2);
			7'd45: u = mk(OP_MUL, R_T1, R_U0, R_V0);
			7'd46: u = mk(OP_MUL, R_T2, R_U1, R_V1);
			7'd47: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd48: u = mk(OP_MUL, R_T2, R_U2, R_V2);
			7'd49: u = mk(OP_ADD, R_UV, R_T1, R_T2);
			7'd50: u = mk(OP_MUL, R_T1, R_V0, R_V0);
			7'd51: u = mk(OP_MUL, R_T2, R_V1, R_V1);
			7'd52: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd53: u = mk(OP_MUL, R_T2, R_V2, R_V2);
			7'd54: u = mk(OP_ADD, R_VV, R_T1, R_T2);
			// wu = bn*(w0.u) + an*(ray.u)
			7'd55: u = mk(OP_MUL, R_T1, R_W0, R_U0);
			7'd56: u = mk(OP_MUL, R_T2, R_W1, R_U1);
			7'd57: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd58: u = mk(OP_MUL, R_T2, R_W2, R_U2);
			7'd59: u = mk(OP_ADD, R_T3, R_T1, R_T2);
			7'd60: u = mk(OP_MUL, R_T1, R_BN, R_T3);
			7'd61: u = mk(OP_MUL, R_T2, R_R0, R_U0);
			7'd62: u = mk(OP_MUL, R_T3, R_R1, R_U1);
			7'd63: u = mk(OP_ADD, R_T2, R_T2, R_T3);
			7'd64: u = mk(OP_MUL, R_T3, R_R2, R_U2);
			7'd65: u = mk(OP_ADD, R_T2, R_T2, R_T3);
			7'd66: u = mk(OP_MUL, R_T2, R_AN, R_T2);
			7'd67: u = mk(OP_ADD, R_WU, R_T1, R_T2);
			// wv = bn*(w0.v) + an*(ray.v)
			7'd68: u = mk(OP_MUL, R_T1, R_W0, R_V0);
			7'd69: u = mk(OP_MUL, R_T2, R_W1, R_V1);
			7'd70: u = mk(OP_ADD, R_T1, R_T1, R_T2);
			7'd71: u = mk(OP_MUL, R_T2, R_W2, R_V2);
			7'd72: u = mk(OP_ADD, R_T3, R_T1, R_T2);
			7'd73: u = mk(OP_MUL, R_T1, R_BN, R_T3);
			7'd74: u = mk(OP_MUL, R_T2, R_R0, R_V0);
			7'd75: u = mk(OP_MUL, R_T3, R_R1, R_V1);
			7'd76: u = mk(OP_ADD, R_T2, R_T2, R_T3);
			7'd77: u = mk(OP_MUL, R_T3, R_R2, R_V2);
			7'd78: u = mk(OP_ADD, R_T2, R_T2, R_T3);
			7'd79: u = mk(OP_MUL, R_T2, R_AN, R_T2);
			7'd80: u = mk(OP_ADD, R_WV, R_T1, R_T2);
			// dd, den, numerators
			7'd81: u = mk(OP_MUL, R_T1, R_UV, R_UV);
			7'd82: u = mk(OP_MUL, R_T2, R_UU, R_VV);
			7'd83: u = mk(OP_SUB, R_DD, R_T1, R_T2);
			7'd84: u = mk(OP_MUL, R_DEN, R_DD, R_BN);
			7'd85: u = mk(OP_MUL, R_T1, R_WV, R_UV);
			7'd86: u = mk(OP_MUL, R_T2, R_WU, R_VV);
			7'd87: u = mk(OP_SUB, R_NX, R_T1, R_T2);
			7'd88: u = mk(OP_MUL, R_T1, R_WU, R_UV);
			7'd89: u = mk(OP_MUL, R_T2, R_WV, R_UU);
			7'd90: u = mk(OP_SUB, R_NY, R_T1, R_T2);
			7'd91: u = mk(OP_SUB, R_T1, R_DEN, R_NX);
			7'd92: u = mk(OP_SUB, R_NZ, R_T1, R_NY);
			7'd93: u = mk(OP_DIV, S_WA, R_NX, R_DEN);
			7'd94: u = mk(OP_DIV, S_WB, R_NY, R_DEN);
			7'd95: u = mk(OP_DIV, S_WZ, R_NZ, R_DEN);
			default: u = mk(OP_END, NA, NA, NA);
		endcase
		return u;
	endfunction

endpackage

[rtl/line_triangle_intersect.sv]
// Line segment / triangle intersection with barycentric weights: top level.
// Depends on lti_pkg and lti_rf.
//
// The block holds one triangle, loaded one vertex per item (req_type 0,
// vertex_index 0..2; index 3 is dropped). A load gives no result. A test
// item (req_type 1) brings a segment and gives one result: hit, t and the
// weights of a, b and c in Q1.16, all zero on a miss. The work is exact: a
// small sequencer walks a 97-step microprogram over a 32-entry register
// file of 256-bit values, using a bit-serial shift-add multiplier and a
// 17-step restoring divider. A test item finishes sooner for small
// coordinates, since each multiply stops once its second operand runs out
// of bits; a miss found early ends the item early. The multiplier handles
// 44 multiplies in a test, at one operand bit per cycle.
// The block takes no item while a test is in flight (in_stall high), but a
// finished result waiting in the output register does not hold off the
// next item.
module line_triangle_intersect
	import lti_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic [1:0]              vertex_index,
	input  logic signed [CRD_W-1:0] start_x,
	input  logic signed [CRD_W-1:0] start_y,
	input  logic signed [CRD_W-1:0] start_z,
	input  logic signed [CRD_W-1:0] end_x,
	input  logic signed [CRD_W-1:0] end_y,
	input  logic signed [CRD_W-1:0] end_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic [RES_W-1:0]        distance_t,
	output logic [RES_W-1:0]        weight_a,
	output logic [RES_W-1:0]        weight_b,
	output logic [RES_W-1:0]        weight_c
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_FETCH = 9'b000000010,
		ST_EXEC  = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_MULW  = 9'b000010000,
		ST_DIVN  = 9'b000100000,
		ST_DIVC  = 9'b001000000,
		ST_DIVS  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t           st_q;
	logic [PC_W-1:0]  pc_q;
	logic             nz_q;
	logic             hit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	// Triangle: a0 a1 a2 b0 b1 b2 c0 c1 c2. Segment: s0 s1 s2 e0 e1 e2.
	logic [CRD_W-1:0] vert_q [9];
	logic [CRD_W-1:0] seg_q  [6];

	// Shared arithmetic registers.
	logic [LTI_W-1:0] ma_q, mb_q, acc_q, num_q, den_q;
	logic             msign_q;
	logic [RES_W-1:0] q_q, t_q, wa_q, wb_q;

	logic             hit_out_q;
	logic [RES_W-1:0] t_out_q, wa_out_q, wb_out_q, wc_out_q;

	uop_t             uop;
	rf_wr_t           rf_wr;
	logic [LTI_W-1:0] rdata_a, rdata_b;
	logic [CRD_W-1:0] crd_a, crd_b;
	logic             in_acc, out_load;
	logic [LTI_W-1:0] div_diff;
	logic             div_bit;
	logic [RES_W-1:0] q_next;
	logic [RES_W-1:0] wc_calc;

	assign uop      = prog(pc_q);
	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (st_q == ST_OUT) && (!out_valid_q || !out_stall);

	lti_rf u_rf (
		.clk     (clk),
		.wr      (rf_wr),
		.raddr_a (uop.a),
		.raddr_b (uop.b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Coordinate select for the difference steps.
	function automatic logic [CRD_W-1:0] pick(logic [RF_AW-1:0] k,
			logic [CRD_W-1:0] v [9], logic [CRD_W-1:0] s [6]);
		logic [CRD_W-1:0] r;
		unique case (k)
			K_A0: r = v[0];
			K_A1: r = v[1];
			K_A2: r = v[2];
			K_B0: r = v[3];
			K_B1: r = v[4];
			K_B2: r = v[5];
			K_C0: r = v[6];
			K_C1: r = v[7];
			K_C2: r = v[8];
			K_S0: r = s[0];
			K_S1: r = s[1];
			K_S2: r = s[2];
			K_E0: r = s[3];
			K_E1: r = s[4];
			K_E2: r = s[5];
			default: r = '0;
		endcase
		return r;
	endfunction

	assign crd_a = pick(uop.a, vert_q, seg_q);
	assign crd_b = pick(uop.b, vert_q, seg_q);

	// Restoring divider step: take den off when it fits.
	assign div_diff = num_q - den_q;
	assign div_bit  = !div_diff[LTI_W-1];
	assign q_next   = {q_q[RES_W-2:0], div_bit};
	assign wc_calc  = RES_ONE - wa_q - wb_q;

	// Register file write: SUBC, ADD and SUB results in EXEC, products in MULW.
	always_comb begin
		rf_wr.we   = 1'b0;
		rf_wr.addr = uop.dst;
		rf_wr.data = '0;
		if (st_q == ST_MULW) begin
			rf_wr.we   = 1'b1;
			rf_wr.data = msign_q ? (~acc_q + LTI_W'(1)) : acc_q;
		end else if (st_q == ST_EXEC) begin
			unique case (uop.op)
				OP_SUBC: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = {{(LTI_W-CRD_W){crd_a[CRD_W-1]}}, crd_a}
						- {{(LTI_W-CRD_W){crd_b[CRD_W-1]}}, crd_b};
				end
				OP_ADD: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rdata_a + rdata_b;
				end
				OP_SUB: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rdata_a - rdata_b;
				end
				default: rf_wr.we = 1'b0;
			endcase
		end
	end

	// Sequencer and triangle store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pc_q        <= '0;
			nz_q        <= 1'b0;
			hit_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				vert_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_acc && !req_type) begin
						// Load a vertex; index three is dropped.
						unique case (vertex_index)
							2'd0: begin
								vert_q[0] <= start_x;
								vert_q[1] <= start_y;
								vert_q[2] <= start_z;
							end
							2'd1: begin
								vert_q[3] <= start_x;
								vert_q[4] <= start_y;
								vert_q[5] <= start_z;
							end
							2'd2: begin
								vert_q[6] <= start_x;
								vert_q[7] <= start_y;
								vert_q[8] <= start_z;
							end
							default: ;
						endcase
					end else if (in_acc) begin
						pc_q  <= '0;
						nz_q  <= 1'b0;
						hit_q <= 1'b0;
						st_q  <= ST_FETCH;
					end
				end
				ST_FETCH: st_q <= ST_EXEC;
				ST_EXEC: begin
					unique case (uop.op)
						OP_SUBC, OP_ADD, OP_SUB: begin
							pc_q <= pc_q + 1'b1;
							st_q <= ST_FETCH;
						end
						OP_MUL: st_q <= ST_MUL;
						OP_TNZ: begin
							nz_q <= nz_q | (|rdata_a);
							pc_q <= pc_q + 1'b1;
							st_q <= ST_FETCH;
						end
						OP_CHK: begin
							if (nz_q) begin
								nz_q <= 1'b0;
								pc_q <= pc_q + 1'b1;
								st_q <= ST_FETCH;
							end else begin
								st_q <= ST_OUT;	// degenerate or parallel
							end
						end
						OP_DIV: st_q <= ST_DIVN;
						OP_END: begin
							hit_q <= 1'b1;
							st_q  <= ST_OUT;
						end
					endcase
				end
				ST_MUL: begin
					if (mb_q == '0) begin
						st_q <= ST_MULW;
					end
				end
				ST_MULW: begin
					pc_q <= pc_q + 1'b1;
					st_q <= ST_FETCH;
				end
				ST_DIVN: st_q <= ST_DIVC;
				ST_DIVC: begin
					// Ratio outside 0..1: miss.
					if (num_q[LTI_W-1] || (den_q < num_q)) begin
						st_q <= ST_OUT;
					end else begin
						cnt_q <= '0;
						st_q  <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						pc_q <= pc_q + 1'b1;
						st_q <= ST_FETCH;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: segment, multiplier, divider, results.
	always_ff @(posedge clk) begin
		if (in_acc && req_type) begin
			seg_q[0] <= start_x;
			seg_q[1] <= start_y;
			seg_q[2] <= start_z;
			seg_q[3] <= end_x;
			seg_q[4] <= end_y;
			seg_q[5] <= end_z;
		end
		if (st_q == ST_EXEC && uop.op == OP_MUL) begin
			ma_q    <= rdata_a[LTI_W-1] ? (~rdata_a + LTI_W'(1)) : rdata_a;
			mb_q    <= rdata_b[LTI_W-1] ? (~rdata_b + LTI_W'(1)) : rdata_b;
			msign_q <= rdata_a[LTI_W-1] ^ rdata_b[LTI_W-1];
			acc_q   <= '0;
		end
		if (st_q == ST_MUL && mb_q != '0) begin
			// Advance one multiplier bit.
			acc_q <= acc_q + (mb_q[0] ? ma_q : '0);
			ma_q  <= ma_q << 1;
			mb_q  <= mb_q >> 1;
		end
		if (st_q == ST_EXEC && uop.op == OP_DIV) begin
			num_q <= rdata_a;
			den_q <= rdata_b;
		end
		if (st_q == ST_DIVN && den_q[LTI_W-1]) begin
			num_q <= ~num_q + LTI_W'(1);
			den_q <= ~den_q + LTI_W'(1);
		end
		if (st_q == ST_DIVC) begin
			q_q <= '0;
		end
		if (st_q == ST_DIVS) begin
			num_q <= (div_bit ? div_diff : num_q) << 1;
			q_q   <= q_next;
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				unique case (uop.dst)
					S_T:     t_q  <= q_next;
					S_WA:    wa_q <= q_next;
					S_WB:    wb_q <= q_next;
					default: ;	// weight c only gates the hit
				endcase
			end
		end
		if (out_load) begin
			hit_out_q <= hit_q;
			t_out_q   <= hit_q ? t_q : '0;
			wa_out_q  <= hit_q ? wa_q : '0;
			wb_out_q  <= hit_q ? wb_q : '0;
			wc_out_q  <= hit_q ? wc_calc : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_out_q;
	assign distance_t = t_out_q;
	assign weight_a   = wa_out_q;
	assign weight_b   = wb_out_q;
	assign weight_c   = wc_out_q;

	// A miss leaves every field at zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (distance_t == '0 && weight_a == '0
			&& weight_b == '0 && weight_c == '0))
		else $error("miss result carries non-zero fields");

	// On a hit the three weights add up to one.
	a_hit_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> ((RES_W+1)'(weight_a) + (RES_W+1)'(weight_b)
			+ (RES_W+1)'(weight_c) == (RES_W+1)'(RES_ONE)))
		else $error("hit weights do not sum to one");

	// The sequencer never runs past the end of the microprogram.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> (pc_q <= PROG_LAST))
		else $error("microprogram counter out of range");

	// No new item is taken in the fetch or divide-step states of a test.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FETCH || st_q == ST_DIVS) |-> in_stall)
		else $error("input accepted during a test");

endmodule

[rtl/lti_rf.sv]
// Register file of the intersection datapath: 32 wide entries, one write
// port, two registered read ports. Depends on lti_pkg.
module lti_rf
	import lti_pkg::*;
(
	input  logic             clk,
	input  rf_wr_t           wr,
	input  logic [RF_AW-1:0] raddr_a,
	input  logic [RF_AW-1:0] raddr_b,
	output logic [LTI_W-1:0] rdata_a,
	output logic [LTI_W-1:0] rdata_b
);

	logic [LTI_W-1:0] mem [RF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
